>>> hdl/ibc_pkg.sv
// Shared types, constants and helper functions of the IMU bias calibrator.
package ibc_pkg;

    localparam int DEFAULT_AVERAGE_SAMPLES = 100;
    localparam int DEFAULT_SAMPLE_WIDTH    = 16;

    localparam int FIELD_W     = 16;
    localparam int OFFSET_W    = 17;
    localparam int AXES        = 6;
    localparam int ACCEL_AXES  = 3;
    localparam int AXIS_W      = 3;
    localparam int ACCEL_Z     = 2;
    localparam int THRESHOLD_W = 16;
    localparam int RUN_W       = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam logic [THRESHOLD_W-1:0]  THRESHOLD_RESET = 16'd400;
    localparam logic [RUN_W-1:0]        RUN_LENGTH_RESET = 8'd100;
    localparam logic signed [FIELD_W-1:0] GRAVITY_RESET = 16'sd16384;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_AVG  = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        OP_PASS       = 2'd0,
        OP_RESTART    = 2'd1,
        OP_ACCUM      = 2'd2,
        OP_ACCUM_LAST = 2'd3
    } t_op;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MOTION_THRESHOLD  = 2'd0,
        CFG_STILL_RUN_LENGTH  = 2'd1,
        CFG_GRAVITY_REFERENCE = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        BK_RUN    = 2'd0,
        BK_START  = 2'd1,
        BK_DIVIDE = 2'd2,
        BK_EMIT   = 2'd3
    } t_back_state;

    typedef struct packed {
        logic                      command;
        logic signed [FIELD_W-1:0] accel_x_raw;
        logic signed [FIELD_W-1:0] accel_y_raw;
        logic signed [FIELD_W-1:0] accel_z_raw;
        logic signed [FIELD_W-1:0] gyro_x_raw;
        logic signed [FIELD_W-1:0] gyro_y_raw;
        logic signed [FIELD_W-1:0] gyro_z_raw;
    } t_ibc_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0] corrected_accel_x;
        logic signed [FIELD_W-1:0] corrected_accel_y;
        logic signed [FIELD_W-1:0] corrected_accel_z;
        logic signed [FIELD_W-1:0] corrected_gyro_x;
        logic signed [FIELD_W-1:0] corrected_gyro_y;
        logic signed [FIELD_W-1:0] corrected_gyro_z;
        logic [1:0]                calibration_phase;
    } t_ibc_out;

    typedef struct packed {
        t_op     op;
        t_phase  phase;
        t_ibc_in sample;
    } t_ibc_item;

    typedef struct packed {
        logic                       valid;
        logic                       last;
        logic [AXIS_W-1:0]          axis;
        logic signed [OFFSET_W-1:0] value;
    } t_ibc_div_wr;

    function automatic int sum_width(input int samples);
        return OFFSET_W + $clog2(samples) + 1;
    endfunction

    // Keeps the low w bits of a field and sign-extends them to the full field width.
    function automatic logic signed [FIELD_W-1:0] narrow(input logic [FIELD_W-1:0] v,
                                                         input int unsigned w);
        logic [FIELD_W-1:0] r;
        for (int b = 0; b < FIELD_W; b++) begin
            r[b] = (b < w) ? v[b] : v[w-1];
        end
        return signed'(r);
    endfunction

endpackage

>>> hdl/ibc_front.sv
// Front end: stillness detection, phase tracking and classification of each transaction.
module ibc_front #(
    parameter int AVERAGE_SAMPLES = ibc_pkg::DEFAULT_AVERAGE_SAMPLES,
    parameter int SAMPLE_WIDTH    = ibc_pkg::DEFAULT_SAMPLE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  ibc_pkg::t_ibc_in                    i_data,
    input  logic [ibc_pkg::THRESHOLD_W-1:0]     i_threshold,
    input  logic [ibc_pkg::RUN_W-1:0]           i_run_length,
    input  logic                                i_full,
    output logic                                o_push,
    output ibc_pkg::t_ibc_item                  o_item
);

    localparam int IDX_W = (AVERAGE_SAMPLES > 1) ? $clog2(AVERAGE_SAMPLES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(AVERAGE_SAMPLES - 1);

    ibc_pkg::t_phase                        r_phase, n_phase;
    logic                                   r_have_prev, n_have_prev;
    logic signed [ibc_pkg::FIELD_W-1:0]     r_prev [ibc_pkg::ACCEL_AXES];
    logic signed [ibc_pkg::FIELD_W-1:0]     n_prev [ibc_pkg::ACCEL_AXES];
    logic [ibc_pkg::RUN_W-1:0]              r_still_run, n_still_run;
    logic [IDX_W-1:0]                       r_idx, n_idx;

    logic signed [ibc_pkg::FIELD_W-1:0]     accel [ibc_pkg::ACCEL_AXES];
    logic signed [ibc_pkg::FIELD_W:0]       diff [ibc_pkg::ACCEL_AXES];
    logic [ibc_pkg::FIELD_W:0]              mag [ibc_pkg::ACCEL_AXES];
    logic [ibc_pkg::ACCEL_AXES-1:0]         still_axis;
    logic [ibc_pkg::RUN_W-1:0]              run_inc;
    logic [ibc_pkg::RUN_W-1:0]              need;
    logic                                   accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    always_comb begin
        accel[0] = ibc_pkg::narrow(i_data.accel_x_raw, SAMPLE_WIDTH);
        accel[1] = ibc_pkg::narrow(i_data.accel_y_raw, SAMPLE_WIDTH);
        accel[2] = ibc_pkg::narrow(i_data.accel_z_raw, SAMPLE_WIDTH);
        for (int a = 0; a < ibc_pkg::ACCEL_AXES; a++) begin
            diff[a] = (ibc_pkg::FIELD_W+1)'(accel[a]) - (ibc_pkg::FIELD_W+1)'(r_prev[a]);
            mag[a]  = diff[a][ibc_pkg::FIELD_W] ? unsigned'(-diff[a]) : unsigned'(diff[a]);
            still_axis[a] = mag[a] < {1'b0, i_threshold};
        end
        if (&still_axis) begin
            run_inc = (r_still_run == {ibc_pkg::RUN_W{1'b1}}) ? r_still_run
                                                               : r_still_run + 1'b1;
        end else begin
            run_inc = '0;
        end
        need = (i_run_length == '0) ? ibc_pkg::RUN_W'(1) : i_run_length;
    end

    always_comb begin
        n_phase     = r_phase;
        n_have_prev = r_have_prev;
        n_prev      = r_prev;
        n_still_run = r_still_run;
        n_idx       = r_idx;
        o_item.op     = ibc_pkg::OP_PASS;
        o_item.sample = i_data;
        if (i_data.command) begin
            o_item.op   = ibc_pkg::OP_RESTART;
            n_phase     = ibc_pkg::PH_WAIT;
            n_have_prev = 1'b0;
            n_still_run = '0;
            n_idx       = '0;
        end else begin
            case (r_phase)
                ibc_pkg::PH_WAIT: begin
                    if (r_have_prev) begin
                        n_still_run = run_inc;
                        if (run_inc >= need) begin
                            n_phase = ibc_pkg::PH_AVG;
                            n_idx   = '0;
                        end
                    end
                    n_prev      = accel;
                    n_have_prev = 1'b1;
                end
                ibc_pkg::PH_AVG: begin
                    if (r_idx == IDX_LAST) begin
                        o_item.op = ibc_pkg::OP_ACCUM_LAST;
                        n_idx     = '0;
                        n_phase   = ibc_pkg::PH_DONE;
                    end else begin
                        o_item.op = ibc_pkg::OP_ACCUM;
                        n_idx     = r_idx + 1'b1;
                    end
                end
                default: begin
                    o_item.op = ibc_pkg::OP_PASS;
                end
            endcase
        end
        o_item.phase = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ibc_pkg::PH_WAIT;
            r_have_prev <= 1'b0;
            r_still_run <= '0;
            r_idx       <= '0;
            for (int a = 0; a < ibc_pkg::ACCEL_AXES; a++) begin
                r_prev[a] <= '0;
            end
        end else if (accept) begin
            r_phase     <= n_phase;
            r_have_prev <= n_have_prev;
            r_still_run <= n_still_run;
            r_idx       <= n_idx;
            r_prev      <= n_prev;
        end
    end

endmodule

>>> hdl/ibc_queue.sv
// Short first-in first-out queue of classified transactions between front and back end.
module ibc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ibc_pkg::t_ibc_item  i_item,
    input  logic                i_pop,
    output logic                o_valid,
    output logic                o_full,
    output ibc_pkg::t_ibc_item  o_item
);

    ibc_pkg::t_ibc_item                 r_mem [ibc_pkg::QUEUE_DEPTH];
    logic [ibc_pkg::QUEUE_PTR_W-1:0]    r_wr_ptr;
    logic [ibc_pkg::QUEUE_PTR_W-1:0]    r_rd_ptr;
    logic [ibc_pkg::QUEUE_CNT_W-1:0]    r_count, n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == ibc_pkg::QUEUE_CNT_W'(ibc_pkg::QUEUE_DEPTH));
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

>>> hdl/ibc_divider.sv
// Divides the six axis sums by the sample count through one shared reciprocal multiplier.
module ibc_divider #(
    parameter int AVERAGE_SAMPLES = ibc_pkg::DEFAULT_AVERAGE_SAMPLES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [ibc_pkg::sum_width(AVERAGE_SAMPLES)-1:0] i_sums [ibc_pkg::AXES],
    output ibc_pkg::t_ibc_div_wr o_wr
);

    localparam int SUM_W   = ibc_pkg::sum_width(AVERAGE_SAMPLES);
    localparam int SHIFT   = SUM_W + $clog2(AVERAGE_SAMPLES);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(AVERAGE_SAMPLES) - 64'd1) / 64'(AVERAGE_SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [ibc_pkg::AXIS_W-1:0] AXIS_LAST = ibc_pkg::AXIS_W'(ibc_pkg::AXES - 1);

    logic                           r_active;
    logic [ibc_pkg::AXIS_W-1:0]     r_axis;
    logic                           r_s1_valid;
    logic [ibc_pkg::AXIS_W-1:0]     r_s1_axis;
    logic                           r_s1_neg;
    logic [SUM_W-1:0]               r_s1_mag;
    logic                           r_s2_valid;
    logic [ibc_pkg::AXIS_W-1:0]     r_s2_axis;
    logic                           r_s2_neg;
    logic [PROD_W-1:0]              r_s2_prod;
    logic signed [SUM_W-1:0]        sel_sum;
    logic signed [ibc_pkg::OFFSET_W-1:0] quot;

    assign sel_sum = i_sums[r_axis];
    assign quot    = signed'(r_s2_prod[SHIFT +: ibc_pkg::OFFSET_W]);

    always_comb begin
        o_wr.valid = r_s2_valid;
        o_wr.last  = (r_s2_axis == AXIS_LAST);
        o_wr.axis  = r_s2_axis;
        o_wr.value = r_s2_neg ? -quot : quot;
    end

    always_ff @(posedge i_clk) begin
        r_s1_axis <= r_axis;
        r_s1_neg  <= sel_sum[SUM_W-1];
        r_s1_mag  <= sel_sum[SUM_W-1] ? unsigned'(-sel_sum) : unsigned'(sel_sum);
        r_s2_axis <= r_s1_axis;
        r_s2_neg  <= r_s1_neg;
        r_s2_prod <= PROD_W'(r_s1_mag) * PROD_W'(RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_axis     <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= r_active;
            r_s2_valid <= r_s1_valid;
            if (i_start) begin
                r_active <= 1'b1;
                r_axis   <= '0;
            end else if (r_active) begin
                r_axis <= r_axis + 1'b1;
                if (r_axis == AXIS_LAST) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

endmodule

>>> hdl/ibc_back.sv
// Back end: accumulation, offset store, bias correction and the registered result stage.
module ibc_back #(
    parameter int AVERAGE_SAMPLES = ibc_pkg::DEFAULT_AVERAGE_SAMPLES,
    parameter int SAMPLE_WIDTH    = ibc_pkg::DEFAULT_SAMPLE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_item_valid,
    input  ibc_pkg::t_ibc_item                  i_item,
    output logic                                o_pop,
    input  logic signed [ibc_pkg::FIELD_W-1:0]  i_gravity,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ibc_pkg::t_ibc_out                   o_out_data
);

    localparam int SUM_W = ibc_pkg::sum_width(AVERAGE_SAMPLES);

    ibc_pkg::t_back_state                   r_state, n_state;
    logic signed [SUM_W-1:0]                r_sums [ibc_pkg::AXES];
    logic signed [ibc_pkg::OFFSET_W-1:0]    r_offsets [ibc_pkg::AXES];
    ibc_pkg::t_ibc_item                     r_held;
    logic                                   r_out_valid;
    ibc_pkg::t_ibc_out                      r_out_data;

    ibc_pkg::t_ibc_div_wr                   div_wr;
    ibc_pkg::t_ibc_item                     src;
    ibc_pkg::t_ibc_out                      out_next;
    logic signed [ibc_pkg::FIELD_W-1:0]     samp [ibc_pkg::AXES];
    logic signed [ibc_pkg::OFFSET_W-1:0]    off [ibc_pkg::AXES];
    logic signed [ibc_pkg::FIELD_W+1:0]     delta [ibc_pkg::AXES];
    logic signed [ibc_pkg::FIELD_W-1:0]     corr [ibc_pkg::AXES];
    logic signed [SUM_W-1:0]                term [ibc_pkg::AXES];
    logic signed [ibc_pkg::FIELD_W:0]       az_term;
    logic                                   out_free;
    logic                                   load_out;
    logic                                   accumulate;
    logic                                   restart;
    logic                                   clear_sums;
    logic                                   hold;
    logic                                   div_start;

    ibc_divider #(
        .AVERAGE_SAMPLES(AVERAGE_SAMPLES)
    ) u_divider (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_sums (r_sums),
        .o_wr   (div_wr)
    );

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        load_out   = 1'b0;
        accumulate = 1'b0;
        restart    = 1'b0;
        clear_sums = 1'b0;
        hold       = 1'b0;
        div_start  = 1'b0;
        case (r_state)
            ibc_pkg::BK_RUN: begin
                if (i_item_valid && out_free) begin
                    o_pop = 1'b1;
                    case (i_item.op)
                        ibc_pkg::OP_RESTART: begin
                            restart    = 1'b1;
                            clear_sums = 1'b1;
                            load_out   = 1'b1;
                        end
                        ibc_pkg::OP_ACCUM: begin
                            accumulate = 1'b1;
                            load_out   = 1'b1;
                        end
                        ibc_pkg::OP_ACCUM_LAST: begin
                            accumulate = 1'b1;
                            hold       = 1'b1;
                            n_state    = ibc_pkg::BK_START;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ibc_pkg::BK_START: begin
                div_start = 1'b1;
                n_state   = ibc_pkg::BK_DIVIDE;
            end
            ibc_pkg::BK_DIVIDE: begin
                if (div_wr.valid && div_wr.last) begin
                    n_state = ibc_pkg::BK_EMIT;
                end
            end
            ibc_pkg::BK_EMIT: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    clear_sums = 1'b1;
                    n_state    = ibc_pkg::BK_RUN;
                end
            end
            default: begin
                n_state = ibc_pkg::BK_RUN;
            end
        endcase
    end

    always_comb begin
        src = (r_state == ibc_pkg::BK_EMIT) ? r_held : i_item;
        samp[0] = ibc_pkg::narrow(src.sample.accel_x_raw, SAMPLE_WIDTH);
        samp[1] = ibc_pkg::narrow(src.sample.accel_y_raw, SAMPLE_WIDTH);
        samp[2] = ibc_pkg::narrow(src.sample.accel_z_raw, SAMPLE_WIDTH);
        samp[3] = ibc_pkg::narrow(src.sample.gyro_x_raw, SAMPLE_WIDTH);
        samp[4] = ibc_pkg::narrow(src.sample.gyro_y_raw, SAMPLE_WIDTH);
        samp[5] = ibc_pkg::narrow(src.sample.gyro_z_raw, SAMPLE_WIDTH);
        az_term = (ibc_pkg::FIELD_W+1)'(samp[ibc_pkg::ACCEL_Z])
                - (ibc_pkg::FIELD_W+1)'(i_gravity);
        for (int a = 0; a < ibc_pkg::AXES; a++) begin
            term[a]  = (a == ibc_pkg::ACCEL_Z) ? SUM_W'(az_term) : SUM_W'(samp[a]);
            off[a]   = restart ? '0 : r_offsets[a];
            delta[a] = (ibc_pkg::FIELD_W+2)'(samp[a]) - (ibc_pkg::FIELD_W+2)'(off[a]);
            corr[a]  = ibc_pkg::narrow(delta[a][ibc_pkg::FIELD_W-1:0], SAMPLE_WIDTH);
        end
        out_next.corrected_accel_x = corr[0];
        out_next.corrected_accel_y = corr[1];
        out_next.corrected_accel_z = corr[2];
        out_next.corrected_gyro_x  = corr[3];
        out_next.corrected_gyro_y  = corr[4];
        out_next.corrected_gyro_z  = corr[5];
        out_next.calibration_phase = src.phase;
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= out_next;
        end
        if (hold) begin
            r_held <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ibc_pkg::BK_RUN;
            r_out_valid <= 1'b0;
            for (int a = 0; a < ibc_pkg::AXES; a++) begin
                r_sums[a]    <= '0;
                r_offsets[a] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            for (int a = 0; a < ibc_pkg::AXES; a++) begin
                if (clear_sums) begin
                    r_sums[a] <= '0;
                end else if (accumulate) begin
                    r_sums[a] <= r_sums[a] + term[a];
                end
                if (restart) begin
                    r_offsets[a] <= '0;
                end
            end
            if (div_wr.valid) begin
                r_offsets[div_wr.axis] <= div_wr.value;
            end
        end
    end

endmodule

>>> hdl/imu_bias_calibrator.sv
// Top level of the IMU bias calibrator: configuration registers and the front and back ends.
//
// The block accepts one six-axis sample per clock cycle while its queue has room and returns
// one corrected sample per transaction, registered in the queue and the result stage, when the
// output side is ready. A transaction that completes the averaging window holds the back end
// while one shared reciprocal multiplier divides the six sums in turn; the four-entry queue
// after the front end keeps accepting input during that time, and input ready falls only when
// that queue fills. Offsets, phase and counters are cleared at reset and by a restart command;
// the three configuration registers should be written only while no transaction is in flight.
module imu_bias_calibrator #(
    parameter int AVERAGE_SAMPLES = ibc_pkg::DEFAULT_AVERAGE_SAMPLES,
    parameter int SAMPLE_WIDTH    = ibc_pkg::DEFAULT_SAMPLE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ibc_pkg::t_ibc_in                    i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ibc_pkg::t_ibc_out                   o_out_data,
    input  logic                                i_cfg_we,
    input  logic [ibc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [ibc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    logic [ibc_pkg::THRESHOLD_W-1:0]        r_motion_threshold;
    logic [ibc_pkg::RUN_W-1:0]              r_still_run_length;
    logic signed [ibc_pkg::FIELD_W-1:0]     r_gravity_reference;

    logic                   push;
    logic                   pop;
    logic                   queue_full;
    logic                   queue_valid;
    ibc_pkg::t_ibc_item     push_item;
    ibc_pkg::t_ibc_item     head_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion_threshold  <= ibc_pkg::THRESHOLD_RESET;
            r_still_run_length  <= ibc_pkg::RUN_LENGTH_RESET;
            r_gravity_reference <= ibc_pkg::GRAVITY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ibc_pkg::CFG_MOTION_THRESHOLD: begin
                    r_motion_threshold <= i_cfg_wdata[ibc_pkg::THRESHOLD_W-1:0];
                end
                ibc_pkg::CFG_STILL_RUN_LENGTH: begin
                    r_still_run_length <= i_cfg_wdata[ibc_pkg::RUN_W-1:0];
                end
                ibc_pkg::CFG_GRAVITY_REFERENCE: begin
                    r_gravity_reference <= signed'(i_cfg_wdata[ibc_pkg::FIELD_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    ibc_front #(
        .AVERAGE_SAMPLES(AVERAGE_SAMPLES),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_data      (i_in_data),
        .i_threshold (r_motion_threshold),
        .i_run_length(r_still_run_length),
        .i_full      (queue_full),
        .o_push      (push),
        .o_item      (push_item)
    );

    ibc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (push_item),
        .i_pop  (pop),
        .o_valid(queue_valid),
        .o_full (queue_full),
        .o_item (head_item)
    );

    ibc_back #(
        .AVERAGE_SAMPLES(AVERAGE_SAMPLES),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_valid(queue_valid),
        .i_item      (head_item),
        .o_pop       (pop),
        .i_gravity   (r_gravity_reference),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> test/tb_imu_bias_calibrator.sv
`timescale 1ns / 1ps
// Self-checking testbench of the IMU bias calibrator with its own predictor of every result.
module tb_imu_bias_calibrator;
    import ibc_pkg::*;

    localparam int AVG_SAMPLES = DEFAULT_AVERAGE_SAMPLES;
    localparam int STALL_LIMIT = 2000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_ibc_in    in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_ibc_out   out_data;
    logic       cfg_we = 1'b0;
    t_cfg_index cfg_index = CFG_MOTION_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    t_ibc_out expected_results [$];
    t_ibc_out oldest_result;
    int       mismatch_count = 0;
    int       results_checked = 0;
    int       samples_sent = 0;
    int       restarts = 0;
    int       calibrations = 0;
    bit       tx_idle = 1'b1;
    bit       rx_idle = 1'b1;
    int       hold_req = 0;

    int          motion_thr;
    int          run_needed;
    int          gravity_ref;
    t_phase      cal_phase;
    bit          have_prev;
    int          prev_accel [ACCEL_AXES];
    int unsigned still_count;
    int unsigned window_count;
    longint      axis_sum [AXES];
    int          axis_offset [AXES];

    imu_bias_calibrator #(
        .AVERAGE_SAMPLES(AVG_SAMPLES),
        .SAMPLE_WIDTH   (DEFAULT_SAMPLE_WIDTH)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_wdata(cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void clear_calibration();
        cal_phase = PH_WAIT;
        have_prev = 1'b0;
        still_count = 0;
        window_count = 0;
        foreach (prev_accel[a]) prev_accel[a] = 0;
        foreach (axis_sum[a]) axis_sum[a] = 0;
        foreach (axis_offset[a]) axis_offset[a] = 0;
    endfunction

    function automatic t_ibc_out predict_correction(input t_ibc_in s);
        int raw [AXES];
        int diff;
        int need;
        bit still;
        t_ibc_out r;
        raw[0] = $signed(s.accel_x_raw);
        raw[1] = $signed(s.accel_y_raw);
        raw[2] = $signed(s.accel_z_raw);
        raw[3] = $signed(s.gyro_x_raw);
        raw[4] = $signed(s.gyro_y_raw);
        raw[5] = $signed(s.gyro_z_raw);
        if (s.command) begin
            clear_calibration();
            restarts++;
        end else if (cal_phase == PH_WAIT) begin
            if (have_prev) begin
                still = 1'b1;
                need = (run_needed == 0) ? 1 : run_needed;
                for (int a = 0; a < ACCEL_AXES; a++) begin
                    diff = raw[a] - prev_accel[a];
                    if (diff < 0) diff = -diff;
                    if (diff >= motion_thr) still = 1'b0;
                end
                if (!still) still_count = 0;
                else if (still_count < 255) still_count++;
                if (still_count >= need) begin
                    cal_phase = PH_AVG;
                    window_count = 0;
                    foreach (axis_sum[a]) axis_sum[a] = 0;
                end
            end
            for (int a = 0; a < ACCEL_AXES; a++) prev_accel[a] = raw[a];
            have_prev = 1'b1;
        end else if (cal_phase == PH_AVG) begin
            for (int a = 0; a < AXES; a++)
                axis_sum[a] += (a == ACCEL_Z) ? raw[a] - gravity_ref : raw[a];
            window_count++;
            if (window_count >= AVG_SAMPLES) begin
                for (int a = 0; a < AXES; a++) begin
                    axis_offset[a] = axis_sum[a] / AVG_SAMPLES;
                    axis_sum[a] = 0;
                end
                window_count = 0;
                cal_phase = PH_DONE;
                calibrations++;
            end
        end
        r.corrected_accel_x = FIELD_W'(raw[0] - axis_offset[0]);
        r.corrected_accel_y = FIELD_W'(raw[1] - axis_offset[1]);
        r.corrected_accel_z = FIELD_W'(raw[2] - axis_offset[2]);
        r.corrected_gyro_x  = FIELD_W'(raw[3] - axis_offset[3]);
        r.corrected_gyro_y  = FIELD_W'(raw[4] - axis_offset[4]);
        r.corrected_gyro_z  = FIELD_W'(raw[5] - axis_offset[5]);
        r.calibration_phase = cal_phase;
        return r;
    endfunction

    function automatic int rand_field();
        logic signed [FIELD_W-1:0] v;
        v = FIELD_W'($urandom);
        return v;
    endfunction

    function automatic int clamp16(input int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic t_ibc_in make_sample(input bit cmd, input int ax, input int ay,
                                            input int az, input int gx, input int gy,
                                            input int gz);
        t_ibc_in s;
        s.command     = cmd;
        s.accel_x_raw = FIELD_W'(ax);
        s.accel_y_raw = FIELD_W'(ay);
        s.accel_z_raw = FIELD_W'(az);
        s.gyro_x_raw  = FIELD_W'(gx);
        s.gyro_y_raw  = FIELD_W'(gy);
        s.gyro_z_raw  = FIELD_W'(gz);
        return s;
    endfunction

    function automatic t_ibc_in uniform(input bit cmd, input int v);
        return make_sample(cmd, v, v, v, v, v, v);
    endfunction

    task automatic send_sample(input t_ibc_in s);
        int gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do @(posedge clk); while (!in_ready);
        expected_results.push_back(predict_correction(s));
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (expected_results.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    task automatic set_config(input int thr, input int run, input int grav);
        logic signed [FIELD_W-1:0] g;
        g = FIELD_W'(grav);
        write_reg(CFG_MOTION_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(CFG_STILL_RUN_LENGTH, {8'd0, run[7:0]});
        write_reg(CFG_GRAVITY_REFERENCE, g);
        cfg_we <= 1'b0;
        motion_thr  = thr & 16'hFFFF;
        run_needed  = run & 8'hFF;
        gravity_ref = g;
    endtask

    task automatic compare_field(input string field, input logic [FIELD_W-1:0] want,
                                 input logic [FIELD_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("ERROR: transaction %0d %s expected %0d got %0d",
                         results_checked, field, $signed(want), $signed(got));
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: transaction %h arrived with nothing expected", out_data);
            end else begin
                oldest_result = expected_results.pop_front();
                results_checked++;
                compare_field("corrected_accel_x", oldest_result.corrected_accel_x,
                              out_data.corrected_accel_x);
                compare_field("corrected_accel_y", oldest_result.corrected_accel_y,
                              out_data.corrected_accel_y);
                compare_field("corrected_accel_z", oldest_result.corrected_accel_z,
                              out_data.corrected_accel_z);
                compare_field("corrected_gyro_x", oldest_result.corrected_gyro_x,
                              out_data.corrected_gyro_x);
                compare_field("corrected_gyro_y", oldest_result.corrected_gyro_y,
                              out_data.corrected_gyro_y);
                compare_field("corrected_gyro_z", oldest_result.corrected_gyro_z,
                              out_data.corrected_gyro_z);
                compare_field("calibration_phase", FIELD_W'(oldest_result.calibration_phase),
                              FIELD_W'(out_data.calibration_phase));
            end
        end
    end

    initial begin
        int stall;
        forever begin
            stall = rx_idle ? $urandom_range(0, 5) : 0;
            if (hold_req > 0) begin
                stall = hold_req;
                hold_req = 0;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && rst_n));
            @(negedge clk);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
            else quiet++;
        end
        $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
        $display("imu_bias_calibrator: mismatch");
        $finish;
    end

    task automatic test_directed_cases();
        set_config(65535, 1, -32768);
        send_sample(uniform(1'b1, 32767));
        send_sample(uniform(1'b0, 32767));
        send_sample(uniform(1'b0, -32768));
        send_sample(uniform(1'b0, -32768));
        send_sample(uniform(1'b0, 32767));
        send_sample(uniform(1'b0, -32768));
        send_sample(uniform(1'b0, 0));
        send_sample(uniform(1'b0, -1));
        send_sample(make_sample(1'b0, 21845, -21846, 21845, -21846, 21845, -21846));
        send_sample(make_sample(1'b1, -21846, 21845, -21846, 21845, -21846, 21845));
        wait_for_results();
        set_config(0, 0, 32767);
        send_sample(uniform(1'b1, 1234));
        repeat (3) send_sample(uniform(1'b0, 1234));
        wait_for_results();
        set_config(1, 0, 0);
        repeat (3) send_sample(uniform(1'b0, -5));
        wait_for_results();
    endtask

    task automatic run_calibration(input int mode, input int tail, input bit squeeze);
        int level [ACCEL_AXES];
        int bias [AXES];
        int v [AXES];
        int span;
        int step;
        int j;
        int breaks_left;
        breaks_left = 2;
        for (int a = 0; a < AXES; a++) bias[a] = rand_field();
        for (int a = 0; a < ACCEL_AXES; a++) level[a] = bias[a];
        send_sample(make_sample(1'b1, rand_field(), rand_field(), rand_field(),
                                rand_field(), rand_field(), rand_field()));
        while (cal_phase != PH_DONE) begin
            if (cal_phase == PH_WAIT) begin
                span = motion_thr - 1;
                if (breaks_left > 0 && motion_thr <= 32768 &&
                    $urandom_range(0, run_needed + 4) == 0) begin
                    // A jolt on one axis breaks the still run.
                    breaks_left--;
                    j = $urandom_range(0, ACCEL_AXES - 1);
                    level[j] = (level[j] + motion_thr <= 32767) ? level[j] + motion_thr
                                                                : level[j] - motion_thr;
                end else begin
                    for (int a = 0; a < ACCEL_AXES; a++) begin
                        step = $urandom_range(0, 2 * span);
                        level[a] = clamp16(level[a] + step - span);
                    end
                end
                send_sample(make_sample(1'b0, level[0], level[1], level[2],
                                        rand_field(), rand_field(), rand_field()));
            end else begin
                if (squeeze && window_count == AVG_SAMPLES - 20) begin
                    hold_req = 80;
                    tx_idle = 1'b0;
                end
                if (window_count == AVG_SAMPLES / 2 && (squeeze || $urandom_range(0, 2) == 0))
                    wait_for_results();
                for (int a = 0; a < AXES; a++) begin
                    case (mode)
                        0: v[a] = rand_field();
                        1: v[a] = -32768;
                        2: v[a] = clamp16(bias[a] + $urandom_range(0, 200) - 100);
                        default: v[a] = 32767;
                    endcase
                end
                if (!squeeze && $urandom_range(0, 199) == 0) begin
                    send_sample(make_sample(1'b1, v[0], v[1], v[2], v[3], v[4], v[5]));
                end else begin
                    send_sample(make_sample(1'b0, v[0], v[1], v[2], v[3], v[4], v[5]));
                end
            end
        end
        repeat (tail) send_sample(make_sample(1'b0, rand_field(), rand_field(), rand_field(),
                                              rand_field(), rand_field(), rand_field()));
    endtask

    task automatic test_calibration_runs();
        int mode;
        for (int k = 0; k < 6; k++) begin
            tx_idle = (k != 2);
            rx_idle = (k != 3);
            case (k)
                0: set_config(400, 255, 16384);
                1: set_config(1, 3, 32767);
                2: set_config(65535, 1, -32768);
                3: set_config($urandom_range(1, 65535), $urandom_range(1, 12), rand_field());
                default: set_config($urandom_range(2, 2000), $urandom_range(1, 12), rand_field());
            endcase
            case (k)
                0: mode = 2;
                1: mode = 1;
                2: mode = 3;
                default: mode = $urandom_range(0, 2);
            endcase
            run_calibration(mode, $urandom_range(3, 10), 1'b0);
            wait_for_results();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_backpressure();
        set_config(2000, 4, 16384);
        run_calibration(2, 5, 1'b1);
        wait_for_results();
        tx_idle = 1'b1;
    endtask

    task automatic test_random_noise();
        int level [ACCEL_AXES];
        for (int a = 0; a < ACCEL_AXES; a++) level[a] = rand_field();
        for (int k = 0; k < 4; k++) begin
            tx_idle = $urandom_range(0, 1);
            rx_idle = $urandom_range(0, 1);
            set_config($urandom_range(1, 65535), $urandom_range(1, 20), rand_field());
            repeat (30) begin
                if ($urandom_range(0, 1) == 0) begin
                    for (int a = 0; a < ACCEL_AXES; a++) level[a] = rand_field();
                end else begin
                    for (int a = 0; a < ACCEL_AXES; a++)
                        level[a] = clamp16(level[a] + $urandom_range(0, 600) - 300);
                end
                send_sample(make_sample($urandom_range(0, 9) == 0, level[0], level[1],
                                        level[2], rand_field(), rand_field(), rand_field()));
            end
            wait_for_results();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin
        clear_calibration();
        motion_thr  = THRESHOLD_RESET;
        run_needed  = RUN_LENGTH_RESET;
        gravity_ref = GRAVITY_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_cases();
        test_calibration_runs();
        test_backpressure();
        test_random_noise();
        wait_for_results();
        repeat (20) @(negedge clk);
        $display("Sent %0d samples with %0d restarts; %0d calibrations ran to completion.",
                 samples_sent, restarts, calibrations);
        $display("Checked %0d transactions under several register settings and stalls.",
                 results_checked);
        if (mismatch_count == 0) begin
            $display("imu_bias_calibrator: match");
        end else begin
            $display("imu_bias_calibrator: mismatch");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/ibc_pkg.sv
hdl/ibc_front.sv
hdl/ibc_queue.sv
hdl/ibc_divider.sv
hdl/ibc_back.sv
hdl/imu_bias_calibrator.sv
test/tb_imu_bias_calibrator.sv
